[rtl/ar3_pkg.sv]
// ----------------------------------------------------------------------------
// ar3_pkg
// shared types, constants and tables of the 3d axis rotation core
// ----------------------------------------------------------------------------
package ar3_pkg;

    // cordic depth, default and upper bound of the arctangent table
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_STAGES_MAX = 30;

    // angle constants, q4.27 radians, one guard bit for the reduction compare
    localparam logic signed [32:0] ANG_PI      = 33'sd421657428;
    localparam logic signed [32:0] ANG_TWO_PI  = 33'sd843314856;
    localparam logic signed [32:0] ANG_HALF_PI = 33'sd210828714;

    // cordic start value, gain k in q.30
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // arctangent of 2^-i, q4.27, rounded to nearest
    localparam logic signed [31:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
        32'sd105414357, 32'sd62229729, 32'sd32880480, 32'sd16690645, 32'sd8377711,
        32'sd4192939,   32'sd2096981,  32'sd1048555,  32'sd524285,   32'sd262144,
        32'sd131072,    32'sd65536,    32'sd32768,    32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,     32'sd1024,     32'sd512,      32'sd256,
        32'sd128,       32'sd64,       32'sd32,       32'sd16,       32'sd8,
        32'sd4,         32'sd2,        32'sd1,        32'sd0,        32'sd0
    };

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        t_axis              func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    // request while the angle is being reduced
    typedef struct packed {
        t_point             pt;
        logic signed [31:0] ang;
    } t_ang_req;

    // state carried down the cordic stages
    typedef struct packed {
        t_point             pt;
        logic               flip;
        logic signed [31:0] ang;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } t_cordic_st;

    // cordic result, cos and sin in q.30, flip still to be applied
    typedef struct packed {
        t_point             pt;
        logic               flip;
        logic signed [31:0] cosv;
        logic signed [31:0] sinv;
    } t_trig;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_result;

endpackage

[rtl/ar3_if.sv]
// ----------------------------------------------------------------------------
// ar3_if
// valid/ready channels of the 3d axis rotation core
// ----------------------------------------------------------------------------

// point and angle request
interface ar3_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] angle;

    modport source (output valid, func, x_in, y_in, z_in, angle, input ready);
    modport sink   (input valid, func, x_in, y_in, z_in, angle, output ready);
endinterface

// rotated point
interface ar3_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               saturated;

    modport source (output valid, x_out, y_out, z_out, saturated, input ready);
    modport sink   (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface

[rtl/ar3_angle_reduce.sv]
// ----------------------------------------------------------------------------
// ar3_angle_reduce
// brings the angle into [-pi, pi], folds it into [-pi/2, pi/2], seeds cordic
// ----------------------------------------------------------------------------
module ar3_angle_reduce import ar3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_ang_req   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cordic_st o_data
);

    localparam int RED_STAGES = 3;
    localparam int NUM_STAGES = RED_STAGES + 1;

    function automatic t_ang_req reduce_step(input t_ang_req d);
        t_ang_req          r;
        logic signed [32:0] a;
        r = d;
        a = {d.ang[31], d.ang};
        if (a > ANG_PI) begin
            a = a - ANG_TWO_PI;
        end else if (a < -ANG_PI) begin
            a = a + ANG_TWO_PI;
        end
        r.ang = a[31:0];
        return r;
    endfunction

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES:0]   w_rdy;
    t_ang_req              r_red  [RED_STAGES];
    t_ang_req              w_red_in [RED_STAGES];
    logic [RED_STAGES-1:0] w_red_vin;
    t_cordic_st            r_fold;
    t_cordic_st            n_fold;

    // a stage moves when it is empty or its successor moves
    assign w_rdy[NUM_STAGES] = i_ready;
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    for (genvar k = 0; k < RED_STAGES; k++) begin : g_red
        if (k == 0) begin : g_first
            assign w_red_in[k]  = i_data;
            assign w_red_vin[k] = i_valid;
        end else begin : g_next
            assign w_red_in[k]  = r_red[k-1];
            assign w_red_vin[k] = r_v[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_red_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_red_vin[k]) begin
                r_red[k] <= reduce_step(w_red_in[k]);
            end
        end
    end

    // fold the outer quadrants and seed the cordic vector
    always_comb begin
        logic signed [32:0] a;
        a             = {r_red[RED_STAGES-1].ang[31], r_red[RED_STAGES-1].ang};
        n_fold.pt     = r_red[RED_STAGES-1].pt;
        n_fold.flip   = 1'b0;
        n_fold.cx     = CORDIC_GAIN;
        n_fold.cy     = '0;
        if (a > ANG_HALF_PI) begin
            a           = a - ANG_PI;
            n_fold.flip = 1'b1;
        end else if (a < -ANG_HALF_PI) begin
            a           = a + ANG_PI;
            n_fold.flip = 1'b1;
        end
        n_fold.ang = a[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[NUM_STAGES-1] <= 1'b0;
        end else if (w_rdy[NUM_STAGES-1]) begin
            r_v[NUM_STAGES-1] <= r_v[RED_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NUM_STAGES-1] && r_v[RED_STAGES-1]) begin
            r_fold <= n_fold;
        end
    end

    assign o_valid = r_v[NUM_STAGES-1];
    assign o_data  = r_fold;

endmodule

[rtl/ar3_cordic.sv]
// ----------------------------------------------------------------------------
// ar3_cordic
// unrolled rotation-mode cordic, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module ar3_cordic import ar3_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cordic_st i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_trig      o_data
);

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   w_rdy;
    logic [STAGES-1:0] w_vin;
    t_cordic_st        r_st  [STAGES];
    t_cordic_st        w_in  [STAGES];
    t_cordic_st        n_st  [STAGES];

    assign w_rdy[STAGES] = i_ready;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        assign w_rdy[i] = !r_v[i] || w_rdy[i+1];

        if (i == 0) begin : g_first
            assign w_in[i]  = i_data;
            assign w_vin[i] = i_valid;
        end else begin : g_next
            assign w_in[i]  = r_st[i-1];
            assign w_vin[i] = r_v[i-1];
        end

        // rotate toward zero residual angle
        always_comb begin
            logic signed [31:0] dx;
            logic signed [31:0] dy;
            dx      = w_in[i].cy >>> i;
            dy      = w_in[i].cx >>> i;
            n_st[i] = w_in[i];
            if (w_in[i].ang >= 0) begin
                n_st[i].cx  = w_in[i].cx - dx;
                n_st[i].cy  = w_in[i].cy + dy;
                n_st[i].ang = w_in[i].ang - ATAN_TAB[i];
            end else begin
                n_st[i].cx  = w_in[i].cx + dx;
                n_st[i].cy  = w_in[i].cy - dy;
                n_st[i].ang = w_in[i].ang + ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (w_rdy[i]) begin
                r_v[i] <= w_vin[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[i] && w_vin[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[STAGES-1];
    assign o_data.pt   = r_st[STAGES-1].pt;
    assign o_data.flip = r_st[STAGES-1].flip;
    assign o_data.cosv = r_st[STAGES-1].cx;
    assign o_data.sinv = r_st[STAGES-1].cy;

endmodule

[rtl/ar3_rotate.sv]
// ----------------------------------------------------------------------------
// ar3_rotate
// multiplies the cross-axis pair by cos and sin, then rounds and saturates
// ----------------------------------------------------------------------------
module ar3_rotate import ar3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_trig   i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    typedef struct packed {
        t_point             pt;
        logic signed [63:0] pc;
        logic signed [63:0] qs;
        logic signed [63:0] qc;
        logic signed [63:0] ps;
    } t_prod;

    // round half up from q.46 to q16.16 and clip to 32 bits, msb is the clip flag
    function automatic logic [32:0] finish(input logic signed [63:0] acc);
        logic signed [63:0] t;
        logic signed [33:0] r;
        logic [32:0]        f;
        t = acc + 64'sd536870912;
        r = t[63:30];
        if (r > 34'sd2147483647) begin
            f = {1'b1, 32'h7fff_ffff};
        end else if (r < -34'sd2147483648) begin
            f = {1'b1, 32'h8000_0000};
        end else begin
            f = {1'b0, r[31:0]};
        end
        return f;
    endfunction

    logic [1:0]         r_v;
    logic [2:0]         w_rdy;
    t_prod              r_prod;
    t_result            r_res;
    logic signed [31:0] w_p;
    logic signed [31:0] w_q;
    logic signed [31:0] w_c;
    logic signed [31:0] w_s;
    t_prod              n_prod;
    t_result            n_res;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    // pick the pair across the axis, p' = p*c - q*s, q' = q*c + p*s
    always_comb begin
        w_c = i_data.flip ? -i_data.cosv : i_data.cosv;
        w_s = i_data.flip ? -i_data.sinv : i_data.sinv;
        case (i_data.pt.func)
            AXIS_X: begin
                w_p = i_data.pt.y;
                w_q = i_data.pt.z;
            end
            AXIS_Y: begin
                w_p = i_data.pt.z;
                w_q = i_data.pt.x;
            end
            default: begin
                w_p = i_data.pt.x;
                w_q = i_data.pt.y;
            end
        endcase
        n_prod.pt = i_data.pt;
        n_prod.pc = 64'(w_p) * 64'(w_c);
        n_prod.qs = 64'(w_q) * 64'(w_s);
        n_prod.qc = 64'(w_q) * 64'(w_c);
        n_prod.ps = 64'(w_p) * 64'(w_s);
    end

    always_comb begin
        logic [32:0] f1;
        logic [32:0] f2;
        f1      = finish(r_prod.pc - r_prod.qs);
        f2      = finish(r_prod.qc + r_prod.ps);
        n_res.x = r_prod.pt.x;
        n_res.y = r_prod.pt.y;
        n_res.z = r_prod.pt.z;
        n_res.sat = 1'b0;
        case (r_prod.pt.func)
            AXIS_X: begin
                n_res.y   = f1[31:0];
                n_res.z   = f2[31:0];
                n_res.sat = f1[32] | f2[32];
            end
            AXIS_Y: begin
                n_res.z   = f1[31:0];
                n_res.x   = f2[31:0];
                n_res.sat = f1[32] | f2[32];
            end
            AXIS_Z: begin
                n_res.x   = f1[31:0];
                n_res.y   = f2[31:0];
                n_res.sat = f1[32] | f2[32];
            end
            default: begin
                n_res.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_prod <= n_prod;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v[1];
    assign o_data  = r_res;

endmodule

[rtl/axis_rotation_3d_core.sv]
// ----------------------------------------------------------------------------
// axis_rotation_3d_core
// rotates a q16.16 point about the x, y or z axis by a q4.27 angle
// ----------------------------------------------------------------------------
// The core takes one request per clock and returns one result per request,
// in order. A request carries a point (x_in, y_in, z_in, signed Q16.16), an
// angle in radians (signed Q4.27) and an axis code in func (0 x, 1 y, 2 z);
// code 3 passes the point through untouched with saturated low. The angle is
// brought into [-pi, pi] by up to three 2*pi corrections, folded into
// [-pi/2, pi/2], and fed to an unrolled CORDIC that yields cos and sin in
// Q.30. The two coordinates across the axis are rotated (for the y axis,
// x gets +z*sin and z gets -x*sin), rounded half up and clipped to 32 bits;
// saturated flags any clip. The pipeline has three reduction stages, one fold
// stage, one stage per CORDIC micro-rotation, one multiply stage and one
// round/saturate stage. Every stage is a register with its own valid bit, so
// a request can enter every cycle and bubbles close up under output
// back-pressure; ready is low only when every stage holds a request and the
// output is stalled.
// ----------------------------------------------------------------------------
module axis_rotation_3d_core import ar3_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ar3_req_if.sink   i_req,
    ar3_rsp_if.source o_rsp
);

    // request entering the angle reduction
    t_ang_req   w_req;

    // reduction to cordic
    logic       w_red_valid;
    logic       w_red_ready;
    t_cordic_st w_red_data;

    // cordic to rotation
    logic       w_trig_valid;
    logic       w_trig_ready;
    t_trig      w_trig_data;

    // rotation result
    t_result    w_res;

    assign w_req.pt.func = t_axis'(i_req.func);
    assign w_req.pt.x    = i_req.x_in;
    assign w_req.pt.y    = i_req.y_in;
    assign w_req.pt.z    = i_req.z_in;
    assign w_req.ang     = i_req.angle;

    // angle reduction and quadrant fold, four stages
    ar3_angle_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (w_req),
        .o_valid (w_red_valid),
        .i_ready (w_red_ready),
        .o_data  (w_red_data)
    );

    // cos and sin, one micro-rotation per stage
    ar3_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_red_valid),
        .o_ready (w_red_ready),
        .i_data  (w_red_data),
        .o_valid (w_trig_valid),
        .i_ready (w_trig_ready),
        .o_data  (w_trig_data)
    );

    // products, rounding and saturation, two stages
    ar3_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_valid),
        .o_ready (w_trig_ready),
        .i_data  (w_trig_data),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (w_res)
    );

    assign o_rsp.x_out     = w_res.x;
    assign o_rsp.y_out     = w_res.y;
    assign o_rsp.z_out     = w_res.z;
    assign o_rsp.saturated = w_res.sat;

endmodule
